// File: rtl/core/ovn_pkg.sv
// ovn_pkg: shared widths, codes and reset values for the octave value noise block.
// No dependencies. Used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package ovn_pkg;

   // interface field widths
   localparam int COORD_W    = 6;
   localparam int SEED_W     = 16;
   localparam int OCT_W      = 3;
   localparam int DECAY_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_OCTAVES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_DECAY = 1'b1;

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // reset values of the config registers
   localparam logic [OCT_W-1:0]   NUM_OCTAVES_RST  = 3'd4;
   localparam logic [DECAY_W-1:0] OCTAVE_DECAY_RST = 16'd4096;

   // default grid side, power of two from 2 to 1024
   localparam int GRID_SIZE_DEF = 64;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // datapath widths, sized for the largest grid (pitch up to 1024)
   localparam int TOP_W      = 26;   // one bilinear row, up to pitch * 0xFFFF
   localparam int V_W        = 37;   // full bilinear blend before the shift
   localparam int W_W        = 40;   // octave weight, Q.16, up to seven octaves
   localparam int W_HALF     = 20;   // weight is multiplied in two 20-bit halves
   localparam int WSUM_W     = 43;
   localparam int NSUM_W     = 59;
   localparam int DECAY_FRAC = 12;   // decay is Q4.12

   localparam logic [W_W-1:0] WEIGHT_ONE = 40'd65536;

endpackage : ovn_pkg

`default_nettype wire

// File: rtl/core/octave_value_noise_2d.sv
// octave_value_noise_2d: a seed write or query is accepted when start is high and busy low.
// A query makes one pass per octave (N = num_octaves, 0 counts as 1) on the single seed
// read port and shared multiplier, then a restoring divide.
// A query blocks new words until done; busy drops in the cycle rsp_valid pulses.
// Results cannot be stalled. Synchronous reset clears control and config registers only;
// the seed store holds no reset value and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module octave_value_noise_2d #(
   parameter int GRID_SIZE = ovn_pkg::GRID_SIZE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic [ovn_pkg::COORD_W-1:0]       req_coord_i,
   input  wire logic [ovn_pkg::COORD_W-1:0]       req_coord_j,
   input  wire logic [ovn_pkg::SEED_W-1:0]        req_seed_value,
   output logic                                   rsp_valid,
   output logic      [ovn_pkg::SEED_W-1:0]        rsp_noise_value,
   input  wire logic                              csr_we,
   input  wire logic [ovn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ovn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int K  = $clog2(GRID_SIZE);
   localparam int XW = (K > ovn_pkg::COORD_W) ? K : ovn_pkg::COORD_W;

   logic [ovn_pkg::OCT_W-1:0]   num_octaves_ff, num_octaves_in;
   logic [ovn_pkg::DECAY_W-1:0] octave_decay_ff, octave_decay_in;

   logic [XW-1:0]               ci_ext, cj_ext;
   logic [K-1:0]                ci, cj;
   logic                        accept;
   logic                        seed_wr;
   logic                        query_go;

   logic [2*K-1:0]              rd_addr;
   logic [ovn_pkg::SEED_W-1:0]  rd_data;
   logic [ovn_pkg::MUL_A_W-1:0] mul_a;
   logic [ovn_pkg::MUL_B_W-1:0] mul_b;
   logic [ovn_pkg::MUL_P_W-1:0] mul_p;

   // config register writes
   always_comb begin
      num_octaves_in  = num_octaves_ff;
      octave_decay_in = octave_decay_ff;
      if (csr_we) begin
         unique case (csr_index)
            ovn_pkg::CSR_NUM_OCTAVES:  num_octaves_in  = csr_wdata[ovn_pkg::OCT_W-1:0];
            ovn_pkg::CSR_OCTAVE_DECAY: octave_decay_in = csr_wdata[ovn_pkg::DECAY_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_octaves_ff  <= ovn_pkg::NUM_OCTAVES_RST;
         octave_decay_ff <= ovn_pkg::OCTAVE_DECAY_RST;
      end else begin
         num_octaves_ff  <= num_octaves_in;
         octave_decay_ff <= octave_decay_in;
      end
   end

   // fold coordinates onto the grid (wrap when the grid is narrower than the port)
   assign ci_ext = XW'(req_coord_i);
   assign cj_ext = XW'(req_coord_j);
   assign ci     = ci_ext[K-1:0];
   assign cj     = cj_ext[K-1:0];

   // command decode
   assign accept   = start & ~busy;
   assign seed_wr  = accept & (req_opcode == ovn_pkg::OP_WRITE);
   assign query_go = accept & (req_opcode == ovn_pkg::OP_QUERY);

   // a seed write at (i, j) lands at row i, column j
   ovn_seed_ram #(
      .GRID_SIZE (GRID_SIZE)
   ) u_seed_ram (
      .clock   (clock),
      .wr_en   (seed_wr),
      .wr_addr ({ci, cj}),
      .wr_data (req_seed_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ovn_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   ovn_engine #(
      .GRID_SIZE (GRID_SIZE)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .query_go        (query_go),
      .query_x         (ci),
      .query_y         (cj),
      .num_octaves     (num_octaves_ff),
      .octave_decay    (octave_decay_ff),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .mul_a           (mul_a),
      .mul_b           (mul_b),
      .mul_p           (mul_p),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule : octave_value_noise_2d

`default_nettype wire

// File: rtl/core/ovn_seed_ram.sv
// ovn_seed_ram: seed grid store, one write port and one read port with registered data.
// Depends on ovn_pkg for the seed width.
`timescale 1ns / 1ps
`default_nettype none

module ovn_seed_ram #(
   parameter int GRID_SIZE = ovn_pkg::GRID_SIZE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [2*$clog2(GRID_SIZE)-1:0]      wr_addr,
   input  wire logic [ovn_pkg::SEED_W-1:0]          wr_data,
   input  wire logic [2*$clog2(GRID_SIZE)-1:0]      rd_addr,
   output logic      [ovn_pkg::SEED_W-1:0]          rd_data
);

   localparam int DEPTH = GRID_SIZE * GRID_SIZE;

   logic [ovn_pkg::SEED_W-1:0] mem_ff [DEPTH];
   logic [ovn_pkg::SEED_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ovn_seed_ram

`default_nettype wire

// File: rtl/core/ovn_mul.sv
// ovn_mul: the shared unsigned multiplier, product registered.
// Depends on ovn_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module ovn_mul (
   input  wire logic                         clock,
   input  wire logic [ovn_pkg::MUL_A_W-1:0]  op_a,
   input  wire logic [ovn_pkg::MUL_B_W-1:0]  op_b,
   output logic      [ovn_pkg::MUL_P_W-1:0]  product
);

   logic [ovn_pkg::MUL_P_W-1:0] prod_in;
   logic [ovn_pkg::MUL_P_W-1:0] prod_ff;

   assign prod_in = ovn_pkg::MUL_P_W'(op_a) * ovn_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule : ovn_mul

`default_nettype wire

// File: rtl/core/ovn_engine.sv
// ovn_engine: query sequencer. Walks the octaves (four seed reads, bilinear blend,
// weight update and accumulate on the shared multiplier), then a restoring divide.
// Depends on ovn_pkg; drives ovn_seed_ram read port and ovn_mul operands.
`timescale 1ns / 1ps
`default_nettype none

module ovn_engine #(
   parameter int GRID_SIZE = ovn_pkg::GRID_SIZE_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 query_go,
   input  wire logic [$clog2(GRID_SIZE)-1:0]         query_x,
   input  wire logic [$clog2(GRID_SIZE)-1:0]         query_y,
   input  wire logic [ovn_pkg::OCT_W-1:0]            num_octaves,
   input  wire logic [ovn_pkg::DECAY_W-1:0]          octave_decay,
   output logic      [2*$clog2(GRID_SIZE)-1:0]       rd_addr,
   input  wire logic [ovn_pkg::SEED_W-1:0]           rd_data,
   output logic      [ovn_pkg::MUL_A_W-1:0]          mul_a,
   output logic      [ovn_pkg::MUL_B_W-1:0]          mul_b,
   input  wire logic [ovn_pkg::MUL_P_W-1:0]          mul_p,
   output logic                                      busy,
   output logic                                      rsp_valid,
   output logic      [ovn_pkg::SEED_W-1:0]           rsp_noise_value
);

   localparam int K   = $clog2(GRID_SIZE);
   localparam int KW  = $clog2(K + 1);
   localparam int PW  = K + 1;
   localparam int DCW = $clog2(ovn_pkg::SEED_W);

   typedef enum logic [1:0] {ST_IDLE, ST_OCT, ST_DIV} state_type;

   // one octave: address issue, four corner products, two blend products,
   // two weight-update products, two accumulate products
   typedef enum logic [3:0] {
      SP_ADDR, SP_S00, SP_S01, SP_S10, SP_S11, SP_TOP, SP_BOT, SP_V,
      SP_DEC_HI, SP_WNEXT, SP_ACC_LO, SP_ACC_HI
   } step_type;

   state_type                        state_ff, state_in;
   step_type                         step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]                    k_ff, k_in;
   logic [ovn_pkg::OCT_W-1:0]        oct_ff, oct_in;
   logic [ovn_pkg::OCT_W-1:0]        last_oct_ff, last_oct_in;
   logic [K-1:0]                     x_ff, x_in;
   logic [K-1:0]                     y_ff, y_in;
   logic [ovn_pkg::TOP_W-1:0]        top_ff, top_in;
   logic [ovn_pkg::TOP_W-1:0]        bot_ff, bot_in;
   logic [ovn_pkg::V_W-1:0]          v_ff, v_in;
   logic [ovn_pkg::SEED_W-1:0]       samp_ff, samp_in;
   logic [ovn_pkg::MUL_P_W-1:0]      wlo_ff, wlo_in;
   logic [ovn_pkg::W_W-1:0]          wnext_ff, wnext_in;
   logic [ovn_pkg::W_W-1:0]          w_ff, w_in;
   logic [ovn_pkg::WSUM_W-1:0]       wsum_ff, wsum_in;
   logic [ovn_pkg::NSUM_W-1:0]       nsum_ff, nsum_in;
   logic [ovn_pkg::NSUM_W-1:0]       dshift_ff, dshift_in;
   logic [ovn_pkg::SEED_W-1:0]       quo_ff, quo_in;
   logic [DCW-1:0]                   div_cnt_ff, div_cnt_in;

   // lattice snap
   logic [PW-1:0]                    pitch;
   logic [PW-1:0]                    low_mask;
   logic [K-1:0]                     x1, x2, y1, y2, bx, by;
   logic [PW-1:0]                    pbx, pby;

   // datapath helpers
   logic [ovn_pkg::W_HALF-1:0]       w_lo, w_hi;
   logic [ovn_pkg::V_W-1:0]          v_sum, v_shr;
   logic [ovn_pkg::MUL_P_W+ovn_pkg::W_HALF-1:0] w_full;
   logic [ovn_pkg::WSUM_W-1:0]       wsum_next;
   logic [ovn_pkg::NSUM_W:0]         div_diff;
   logic                             div_ge;

   // snap to the pitch lattice; the far corner wraps around the grid
   always_comb begin
      pitch    = PW'(1) << k_ff;
      low_mask = pitch - PW'(1);
      x1       = x_ff & ~low_mask[K-1:0];
      y1       = y_ff & ~low_mask[K-1:0];
      x2       = x1 + pitch[K-1:0];
      y2       = y1 + pitch[K-1:0];
      bx       = x_ff & low_mask[K-1:0];
      by       = y_ff & low_mask[K-1:0];
      pbx      = pitch - PW'(bx);
      pby      = pitch - PW'(by);
   end

   // corner reads: store is indexed by row y then column x
   always_comb begin
      case (step_ff)
         SP_ADDR: rd_addr = {y1, x1};
         SP_S00:  rd_addr = {y1, x2};
         SP_S01:  rd_addr = {y2, x1};
         default: rd_addr = {y2, x2};
      endcase
   end

   assign w_lo = w_ff[ovn_pkg::W_HALF-1:0];
   assign w_hi = w_ff[ovn_pkg::W_W-1:ovn_pkg::W_HALF];

   // multiplier operand select per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         SP_S00: begin
            mul_a = ovn_pkg::MUL_A_W'(rd_data);
            mul_b = ovn_pkg::MUL_B_W'(pbx);
         end
         SP_S01: begin
            mul_a = ovn_pkg::MUL_A_W'(rd_data);
            mul_b = ovn_pkg::MUL_B_W'(bx);
         end
         SP_S10: begin
            mul_a = ovn_pkg::MUL_A_W'(rd_data);
            mul_b = ovn_pkg::MUL_B_W'(pbx);
         end
         SP_S11: begin
            mul_a = ovn_pkg::MUL_A_W'(rd_data);
            mul_b = ovn_pkg::MUL_B_W'(bx);
         end
         SP_TOP: begin
            mul_a = ovn_pkg::MUL_A_W'(top_ff);
            mul_b = ovn_pkg::MUL_B_W'(pby);
         end
         SP_BOT: begin
            mul_a = ovn_pkg::MUL_A_W'(bot_ff);
            mul_b = ovn_pkg::MUL_B_W'(by);
         end
         SP_V: begin
            mul_a = ovn_pkg::MUL_A_W'(w_lo);
            mul_b = octave_decay;
         end
         SP_DEC_HI: begin
            mul_a = ovn_pkg::MUL_A_W'(w_hi);
            mul_b = octave_decay;
         end
         SP_WNEXT: begin
            mul_a = ovn_pkg::MUL_A_W'(w_lo);
            mul_b = samp_ff;
         end
         SP_ACC_LO: begin
            mul_a = ovn_pkg::MUL_A_W'(w_hi);
            mul_b = samp_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // blend result, weight product and divider compare
   always_comb begin
      v_sum     = v_ff + ovn_pkg::V_W'(mul_p);
      v_shr     = v_sum >> {k_ff, 1'b0};
      w_full    = {mul_p, ovn_pkg::W_HALF'(0)}
                  + (ovn_pkg::MUL_P_W + ovn_pkg::W_HALF)'(wlo_ff);
      wsum_next = wsum_ff + ovn_pkg::WSUM_W'(w_ff);
      div_diff  = {1'b0, nsum_ff} - {1'b0, dshift_ff};
      div_ge    = ~div_diff[ovn_pkg::NSUM_W];
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      k_in         = k_ff;
      oct_in       = oct_ff;
      last_oct_in  = last_oct_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      v_in         = v_ff;
      samp_in      = samp_ff;
      wlo_in       = wlo_ff;
      wnext_in     = wnext_ff;
      w_in         = w_ff;
      wsum_in      = wsum_ff;
      nsum_in      = nsum_ff;
      dshift_in    = dshift_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in    = ST_OCT;
               step_in     = SP_ADDR;
               k_in        = KW'(K);
               oct_in      = '0;
               // zero octaves runs as one
               last_oct_in = (num_octaves == '0) ? '0 : num_octaves - 1'b1;
               x_in        = query_x;
               y_in        = query_y;
               w_in        = ovn_pkg::WEIGHT_ONE;
               wsum_in     = '0;
               nsum_in     = '0;
            end
         end

         ST_OCT: begin
            step_in = step_type'(step_ff + 4'd1);
            case (step_ff)
               SP_S01:    top_in = ovn_pkg::TOP_W'(mul_p);
               SP_S10:    top_in = top_ff + ovn_pkg::TOP_W'(mul_p);
               SP_S11:    bot_in = ovn_pkg::TOP_W'(mul_p);
               SP_TOP:    bot_in = bot_ff + ovn_pkg::TOP_W'(mul_p);
               SP_BOT:    v_in   = ovn_pkg::V_W'(mul_p);
               SP_V:      samp_in = v_shr[ovn_pkg::SEED_W-1:0];
               SP_DEC_HI: wlo_in = mul_p;
               SP_WNEXT:  wnext_in = w_full[ovn_pkg::DECAY_FRAC +: ovn_pkg::W_W];
               SP_ACC_LO: nsum_in = nsum_ff + ovn_pkg::NSUM_W'(mul_p);
               SP_ACC_HI: begin
                  nsum_in = nsum_ff + ovn_pkg::NSUM_W'({mul_p, ovn_pkg::W_HALF'(0)});
                  wsum_in = wsum_next;
                  w_in    = wnext_ff;
                  oct_in  = oct_ff + 1'b1;
                  step_in = SP_ADDR;
                  // pitch stops at one
                  if (k_ff != '0) begin
                     k_in = k_ff - 1'b1;
                  end
                  if (oct_ff == last_oct_ff) begin
                     state_in   = ST_DIV;
                     dshift_in  = ovn_pkg::NSUM_W'({wsum_next, (ovn_pkg::SEED_W-1)'(0)});
                     div_cnt_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_DIV: begin
            // one quotient bit per cycle; the sum never reaches 2^16 weight sums
            if (div_ge) begin
               nsum_in = div_diff[ovn_pkg::NSUM_W-1:0];
            end
            quo_in     = {quo_ff[ovn_pkg::SEED_W-2:0], div_ge};
            dshift_in  = dshift_ff >> 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCW'(ovn_pkg::SEED_W - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      oct_ff      <= oct_in;
      last_oct_ff <= last_oct_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      v_ff        <= v_in;
      samp_ff     <= samp_in;
      wlo_ff      <= wlo_in;
      wnext_ff    <= wnext_in;
      w_ff        <= w_in;
      wsum_ff     <= wsum_in;
      nsum_ff     <= nsum_in;
      dshift_ff   <= dshift_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = quo_ff;

endmodule : ovn_engine

`default_nettype wire

// File: sim/octave_noise_checker.sv
// octave_noise_checker: watches the request, response and csr ports of the noise block,
// predicts every query result and compares it with what comes back.
// Depends on ovn_pkg for widths, opcodes and register indexes.
`timescale 1ns / 1ps

module octave_noise_checker #(
   parameter int GRID = ovn_pkg::GRID_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_opcode,
   input  logic [ovn_pkg::COORD_W-1:0]     req_coord_i,
   input  logic [ovn_pkg::COORD_W-1:0]     req_coord_j,
   input  logic [ovn_pkg::SEED_W-1:0]      req_seed_value,
   input  logic                            rsp_valid,
   input  logic [ovn_pkg::SEED_W-1:0]      rsp_noise_value,
   input  logic                            csr_we,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ovn_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                     pending,
   output int unsigned                     mismatches
);
   import ovn_pkg::*;

   localparam int GRID_LOG = $clog2(GRID);
   localparam logic [63:0] AXIS_MASK = 64'(GRID - 1);

   // local copy of the seed grid and the two registers
   logic [SEED_W-1:0]  seed_grid [0:GRID*GRID-1];
   logic [OCT_W-1:0]   octaves_cfg;
   logic [DECAY_W-1:0] decay_cfg;

   // noise values still owed by the block, oldest first
   logic [SEED_W-1:0]  owed_noise [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic flag_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
   endtask

   // octave sum at (qx, qy) with the current registers and seed grid
   function automatic logic [SEED_W-1:0] blend_octaves(input logic [COORD_W-1:0] qx,
                                                       input logic [COORD_W-1:0] qy);
      int unsigned shift_k;
      int unsigned passes;
      int unsigned oct;
      logic [63:0] px, py, pitch, x1, y1, x2, y2, bx, by;
      logic [63:0] s00, s01, s10, s11, row_a, row_b, mix, samp;
      logic [63:0] wgt, nsum, wsum, quot;
      px      = 64'(qx) & AXIS_MASK;
      py      = 64'(qy) & AXIS_MASK;
      shift_k = GRID_LOG;
      passes  = (octaves_cfg == '0) ? 1 : octaves_cfg;
      wgt     = 64'd65536;
      nsum    = '0;
      wsum    = '0;
      for (oct = 0; oct < passes; oct++) begin
         pitch = 64'd1 << shift_k;
         x1    = (px >> shift_k) << shift_k;
         y1    = (py >> shift_k) << shift_k;
         x2    = (x1 + pitch) & AXIS_MASK;
         y2    = (y1 + pitch) & AXIS_MASK;
         bx    = px - x1;
         by    = py - y1;
         // grid is read row = y, column = x
         s00   = 64'(seed_grid[y1 * GRID + x1]);
         s01   = 64'(seed_grid[y1 * GRID + x2]);
         s10   = 64'(seed_grid[y2 * GRID + x1]);
         s11   = 64'(seed_grid[y2 * GRID + x2]);
         row_a = (pitch - bx) * s00 + bx * s01;
         row_b = (pitch - bx) * s10 + bx * s11;
         mix   = (pitch - by) * row_a + by * row_b;
         samp  = mix >> (2 * shift_k);
         nsum  = nsum + wgt * samp;
         wsum  = wsum + wgt;
         wgt   = (wgt * 64'(decay_cfg)) >> DECAY_FRAC;
         if (shift_k > 0)
            shift_k--;
      end
      quot = nsum / wsum;
      if (quot > 64'hFFFF)
         quot = 64'hFFFF;
      return quot[SEED_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         octaves_cfg = NUM_OCTAVES_RST;
         decay_cfg   = OCTAVE_DECAY_RST;
         owed_noise.delete();
      end else begin
         // response word: compare with the oldest owed value
         if (rsp_valid) begin
            if (owed_noise.size() == 0)
               flag_mismatch($sformatf("unexpected noise word %h", rsp_noise_value));
            else if (rsp_noise_value !== owed_noise[0]) begin
               flag_mismatch($sformatf("noise_value got %h want %h",
                                       rsp_noise_value, owed_noise[0]));
               void'(owed_noise.pop_front());
            end else
               void'(owed_noise.pop_front());
         end
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_NUM_OCTAVES)
               octaves_cfg = csr_wdata[OCT_W-1:0];
            else if (csr_index == CSR_OCTAVE_DECAY)
               decay_cfg = csr_wdata[DECAY_W-1:0];
         end
         // accepted request word
         if (start && !busy) begin
            if (req_opcode == OP_WRITE)
               seed_grid[(int'(req_coord_i) & (GRID - 1)) * GRID
                         + (int'(req_coord_j) & (GRID - 1))] = req_seed_value;
            else
               owed_noise.insert(owed_noise.size(),
                                 blend_octaves(req_coord_i, req_coord_j));
         end
      end
      pending <= owed_noise.size();
   end

endmodule

// File: sim/tb_octave_value_noise_2d.sv
// tb_octave_value_noise_2d: drives seed writes, queries and register settings into the
// noise block and gives the verdict. Depends on ovn_pkg, octave_value_noise_2d and
// octave_noise_checker.
`timescale 1ns / 1ps

module tb_octave_value_noise_2d;
   import ovn_pkg::*;

   localparam int GRID         = GRID_SIZE_DEF;
   localparam int GRID_LOG     = $clog2(GRID);
   localparam int DRAIN_CYCLES = 12 * 7 + 16 + 20;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_WORDS  = 200;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_opcode;
   logic [COORD_W-1:0]    req_coord_i;
   logic [COORD_W-1:0]    req_coord_j;
   logic [SEED_W-1:0]     req_seed_value;
   logic                  rsp_valid;
   logic [SEED_W-1:0]     rsp_noise_value;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           pending;
   int unsigned           mismatches;
   int unsigned           cycles;

   // which grid entries have been written, so no query reads an unwritten one
   bit                    seeded [0:GRID*GRID-1];
   int unsigned           words_sent;
   logic [OCT_W-1:0]      octaves_now;

   octave_value_noise_2d #(.GRID_SIZE(GRID)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_coord_i     (req_coord_i),
      .req_coord_j     (req_coord_j),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   octave_noise_checker #(.GRID(GRID)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_coord_i     (req_coord_i),
      .req_coord_j     (req_coord_j),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending         (pending),
      .mismatches      (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // random idle cycles before a word, each cycle idle with odds 37 in 100;
   // none inside the quiet stretch
   task automatic pace();
      if (!(words_sent >= 700 && words_sent < 950)) begin
         while ($urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // present one request word and hold it until accepted; start stays high afterwards
   task automatic send_word(input logic op, input logic [COORD_W-1:0] ci,
                            input logic [COORD_W-1:0] cj, input logic [SEED_W-1:0] val);
      pace();
      if (op == OP_WRITE)
         seeded[(int'(ci) & (GRID - 1)) * GRID + (int'(cj) & (GRID - 1))] = 1'b1;
      req_opcode     <= op;
      req_coord_i    <= ci;
      req_coord_j    <= cj;
      req_seed_value <= val;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   function automatic logic [SEED_W-1:0] pick_seed();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SEED_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // write every grid entry the query will read that is still unwritten, then query
   task automatic seeded_query(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
      int unsigned shift_k;
      int unsigned passes;
      int unsigned oct;
      int unsigned pitch, x1, y1;
      int unsigned xs [2];
      int unsigned ys [2];
      shift_k = GRID_LOG;
      passes  = (octaves_now == '0) ? 1 : octaves_now;
      for (oct = 0; oct < passes; oct++) begin
         pitch = 1 << shift_k;
         x1    = ((int'(qx) & (GRID - 1)) >> shift_k) << shift_k;
         y1    = ((int'(qy) & (GRID - 1)) >> shift_k) << shift_k;
         xs[0] = x1;
         xs[1] = (x1 + pitch) & (GRID - 1);
         ys[0] = y1;
         ys[1] = (y1 + pitch) & (GRID - 1);
         foreach (ys[a])
            foreach (xs[b])
               if (!seeded[ys[a] * GRID + xs[b]])
                  send_word(OP_WRITE, COORD_W'(ys[a]), COORD_W'(xs[b]), pick_seed());
         if (shift_k > 0)
            shift_k--;
      end
      send_word(OP_QUERY, qx, qy, SEED_W'($urandom_range(0, 65535)));
   endtask

   // wait until the block is quiet, then write both registers
   task automatic set_mode(input logic [OCT_W-1:0] octs, input logic [DECAY_W-1:0] decay);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_OCTAVES;
      csr_wdata <= CSR_DATA_W'(octs);
      @(posedge clock);
      csr_index <= CSR_OCTAVE_DECAY;
      csr_wdata <= decay;
      @(posedge clock);
      csr_we    <= 1'b0;
      octaves_now = octs;
   endtask

   task automatic random_word();
      if ($urandom_range(99) < 55)
         seeded_query(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
      else
         send_word(OP_WRITE, COORD_W'($urandom_range(0, 63)),
                   COORD_W'($urandom_range(0, 63)), pick_seed());
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_end;
      logic [OCT_W-1:0]   octs;
      logic [DECAY_W-1:0] decay;

      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_WRITE;
      req_coord_i    = '0;
      req_coord_j    = '0;
      req_seed_value = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_NUM_OCTAVES;
      csr_wdata      = '0;
      words_sent     = 0;
      octaves_now    = NUM_OCTAVES_RST;
      foreach (seeded[n])
         seeded[n] = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corner coordinates, extreme seeds, overwrite, reset settings
      send_word(OP_WRITE, 6'd0, 6'd0, 16'h0000);
      send_word(OP_WRITE, 6'd63, 6'd63, 16'hFFFF);
      send_word(OP_WRITE, 6'd0, 6'd63, 16'hAAAA);
      send_word(OP_WRITE, 6'd63, 6'd0, 16'h5555);
      seeded_query(6'd0, 6'd0);
      seeded_query(6'd63, 6'd63);
      seeded_query(6'd0, 6'd63);
      seeded_query(6'd63, 6'd0);
      send_word(OP_WRITE, 6'd0, 6'd0, 16'hFFFF);
      seeded_query(6'd0, 6'd0);
      seeded_query(6'd21, 6'd42);

      // random phases; the first ones hit the register extremes
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       begin octs = 3'd7; decay = 16'hFFFF; end
            1:       begin octs = 3'd0; decay = 16'h0000; end
            2:       begin octs = 3'd7; decay = 16'h0000; end
            3:       begin octs = 3'd1; decay = 16'h0001; end
            4:       begin octs = 3'd4; decay = 16'h1000; end
            default: begin
               octs  = OCT_W'($urandom_range(0, 7));
               decay = DECAY_W'($urandom_range(0, 65535));
            end
         endcase
         set_mode(octs, decay);
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end)
            random_word();
      end

      // drain outstanding noise words, then wait out DRAIN_CYCLES of quiet
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
